// ===== hdl/swc_pkg.sv =====
// Shared types and constants of the sliding-window covariance block.
package swc_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int DIMENSION      = 6;
  localparam int DIM_W          = 3;
  localparam int SAMPLE_W       = 32;
  localparam int VAL_W          = 64;
  localparam int IDX_W          = 3;
  localparam int COUNT_W        = 5;
  localparam int WLEN_W         = 5;
  localparam int PER_W          = 8;
  localparam int CFG_W          = 8;
  localparam int CFG_IDX_W      = 1;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(10);
  localparam logic [PER_W-1:0]  PER_RESET  = PER_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN       = 1'b0,
    CFG_RECOMPUTE_PERIOD = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pos_x;
    logic signed [SAMPLE_W-1:0] pos_y;
    logic signed [SAMPLE_W-1:0] pos_z;
    logic signed [SAMPLE_W-1:0] range_a0;
    logic signed [SAMPLE_W-1:0] range_a1;
    logic signed [SAMPLE_W-1:0] range_a2;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] cov_value;
    logic [COUNT_W-1:0]      sample_count;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic             take_in;
    logic             wr_sample;
    logic             update;
    logic             clr;
    logic             acc_sum;
    logic             div_start;
    logic             div_mean;
    logic             wr_mean;
    logic             rd_mean;
    logic             ld_mi;
    logic             ld_mj;
    logic             ld_di;
    logic             ld_dj;
    logic             mul;
    logic             acc_prod;
    logic             load_out;
    logic [DIM_W-1:0] dim;
    logic [DIM_W-1:0] mean_idx;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } swc_cmd_t;

  typedef struct packed {
    logic recompute;
    logic div_busy;
    logic out_free;
  } swc_sts_t;

endpackage

// ===== hdl/swc_div.sv =====
// Shared signed divider, one quotient bit per cycle, truncates toward zero.
module swc_div
  import swc_pkg::*;
#(
  parameter int DEN_W = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    busy,
  output logic signed [VAL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] mag;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [DEN_W:0]   rem_shift;

  assign rem_shift = {rem, mag[VAL_W-1]};
  assign quotient  = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VAL_W);
      neg  <= dividend[VAL_W-1];
      mag  <= dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
      rem  <= '0;
    end else if (busy) begin
      if (rem_shift >= {1'b0, divisor}) begin
        rem <= DEN_W'(rem_shift - {1'b0, divisor});
        mag <= {mag[VAL_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DEN_W-1:0];
        mag <= {mag[VAL_W-2:0], 1'b0};
      end
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/swc_ctrl.sv =====
// Sequencer: stores the sample, then, on a recompute, walks means and lower-triangle entries.
module swc_ctrl
  import swc_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  swc_sts_t                             sts,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]      n_cnt,
  output swc_cmd_t                             cmd,
  output logic [$clog2(WINDOW_MAX)-1:0]        k_idx
);

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_UPD, S_CHK,
    S_M_START, S_M_RD, S_M_ACC, S_M_DIV, S_M_WAIT,
    S_C_LDI, S_C_LDJ, S_C_XI, S_C_XJ, S_C_DJ, S_C_MUL, S_C_ACC,
    S_C_DIV, S_C_WAIT, S_C_OUT
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] dim;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [SLOT_W-1:0] k;
  logic             k_end;

  assign k_end    = (CNT_W'(k) + CNT_W'(1)) == n_cnt;
  assign k_idx    = k;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.row       = i;
    cmd.col       = j;
    cmd.dim       = i[DIM_W-1:0];
    cmd.mean_idx  = i[DIM_W-1:0];
    case (state)
      S_IDLE:    cmd.take_in = in_valid;
      S_WR: begin
        cmd.wr_sample = 1'b1;
        cmd.dim       = dim;
      end
      S_UPD:     cmd.update = 1'b1;
      S_M_START: cmd.clr = 1'b1;
      S_M_ACC:   cmd.acc_sum = 1'b1;
      S_M_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_mean  = 1'b1;
      end
      S_M_WAIT:  cmd.wr_mean = !sts.div_busy;
      S_C_LDI: begin
        cmd.clr     = 1'b1;
        cmd.rd_mean = 1'b1;
      end
      S_C_LDJ: begin
        cmd.rd_mean  = 1'b1;
        cmd.mean_idx = j[DIM_W-1:0];
        cmd.ld_mi    = 1'b1;
      end
      S_C_XI:    cmd.ld_mj = 1'b1;
      S_C_XJ: begin
        cmd.dim   = j[DIM_W-1:0];
        cmd.ld_di = 1'b1;
      end
      S_C_DJ:    cmd.ld_dj = 1'b1;
      S_C_MUL:   cmd.mul = 1'b1;
      S_C_ACC:   cmd.acc_prod = 1'b1;
      S_C_DIV:   cmd.div_start = 1'b1;
      S_C_OUT:   cmd.load_out = sts.out_free;
      default:   cmd.clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dim   <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          dim <= '0;
          if (in_valid) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (dim == DIM_W'(DIMENSION - 1)) begin
            state <= S_UPD;
          end else begin
            dim <= dim + DIM_W'(1);
          end
        end
        S_UPD: state <= S_CHK;
        S_CHK: begin
          i     <= '0;
          state <= sts.recompute ? S_M_START : S_IDLE;
        end
        S_M_START: begin
          k     <= '0;
          state <= S_M_RD;
        end
        S_M_RD: state <= S_M_ACC;
        S_M_ACC: begin
          if (k_end) begin
            state <= S_M_DIV;
          end else begin
            k     <= k + SLOT_W'(1);
            state <= S_M_RD;
          end
        end
        S_M_DIV: state <= S_M_WAIT;
        S_M_WAIT: begin
          if (!sts.div_busy) begin
            if (i == IDX_W'(DIMENSION - 1)) begin
              i     <= '0;
              j     <= '0;
              state <= S_C_LDI;
            end else begin
              i     <= i + IDX_W'(1);
              state <= S_M_START;
            end
          end
        end
        S_C_LDI: begin
          k     <= '0;
          state <= S_C_LDJ;
        end
        S_C_LDJ: state <= S_C_XI;
        S_C_XI:  state <= S_C_XJ;
        S_C_XJ:  state <= S_C_DJ;
        S_C_DJ:  state <= S_C_MUL;
        S_C_MUL: state <= S_C_ACC;
        S_C_ACC: begin
          if (k_end) begin
            state <= S_C_DIV;
          end else begin
            k     <= k + SLOT_W'(1);
            state <= S_C_XI;
          end
        end
        S_C_DIV: state <= S_C_WAIT;
        S_C_WAIT: begin
          if (!sts.div_busy) begin
            state <= S_C_OUT;
          end
        end
        S_C_OUT: begin
          // hold until the output register frees up
          if (sts.out_free) begin
            if (j == i) begin
              j <= '0;
              if (i == IDX_W'(DIMENSION - 1)) begin
                state <= S_IDLE;
              end else begin
                i     <= i + IDX_W'(1);
                state <= S_C_LDI;
              end
            end else begin
              j     <= j + IDX_W'(1);
              state <= S_C_LDI;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/swc_dp.sv =====
// Datapath: sample store, counters, means, deviation products and output register.
module swc_dp
  import swc_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  in_t                                in_data,
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data,
  input  swc_cmd_t                           cmd,
  input  logic [$clog2(WINDOW_MAX)-1:0]      k_idx,
  output swc_sts_t                           sts,
  output logic [$clog2(WINDOW_MAX+1)-1:0]    n_cnt,
  output logic                               out_valid,
  input  logic                               out_stall,
  output out_t                               out_data
);

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int CW     = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int XW     = CW + 1;
  localparam int ADDR_W = SLOT_W + DIM_W;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int D_W    = SAMPLE_W + 1;
  localparam int P_W    = 2 * D_W;

  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic [WLEN_W-1:0]          wlen;
  logic [PER_W-1:0]           period;
  logic [SLOT_W-1:0]          write_slot;
  logic [CNT_W-1:0]           fill_count;
  logic [PER_W-1:0]           period_count;
  logic                       recompute;
  in_t                        in_q;

  logic signed [SAMPLE_W-1:0] mem [2**ADDR_W];
  logic signed [SAMPLE_W-1:0] mean_mem [DIMENSION];
  logic signed [SAMPLE_W-1:0] rd;
  logic signed [SAMPLE_W-1:0] mean_rd;
  logic signed [SAMPLE_W-1:0] mi;
  logic signed [SAMPLE_W-1:0] mj;
  logic signed [D_W-1:0]      di;
  logic signed [D_W-1:0]      dj;
  logic signed [P_W-1:0]      prod;
  logic signed [SUM_W-1:0]    sum;
  logic signed [VAL_W-1:0]    acc;

  logic signed [SAMPLE_W-1:0] word;
  logic [SLOT_W:0]            back_raw;
  logic [SLOT_W-1:0]          back_slot;
  logic [XW-1:0]              wlen_x;
  logic [XW-1:0]              wl_eff;
  logic [XW-1:0]              fill_p1;
  logic [PER_W-1:0]           per_eff;
  logic [PER_W-1:0]           pc_p1;
  logic signed [VAL_W-1:0]    prod_sat;
  logic signed [VAL_W:0]      acc_sum;
  logic signed [VAL_W-1:0]    acc_next;
  logic signed [VAL_W-1:0]    dividend;
  logic signed [VAL_W-1:0]    quotient;
  logic                       div_busy;

  always_comb begin
    case (cmd.dim)
      DIM_W'(0): word = in_q.pos_x;
      DIM_W'(1): word = in_q.pos_y;
      DIM_W'(2): word = in_q.pos_z;
      DIM_W'(3): word = in_q.range_a0;
      DIM_W'(4): word = in_q.range_a1;
      DIM_W'(5): word = in_q.range_a2;
      default:   word = in_q.pos_x;
    endcase
  end

  // slot of the k-th newest sample
  assign back_raw  = {1'b0, write_slot} + (SLOT_W+1)'(WINDOW_MAX - 1) - {1'b0, k_idx};
  assign back_slot = (back_raw >= (SLOT_W+1)'(WINDOW_MAX)) ?
                     SLOT_W'(back_raw - (SLOT_W+1)'(WINDOW_MAX)) : back_raw[SLOT_W-1:0];

  assign wlen_x  = XW'(wlen);
  assign wl_eff  = (wlen == '0) ? XW'(1) :
                   (wlen_x > XW'(WINDOW_MAX)) ? XW'(WINDOW_MAX) : wlen_x;
  assign fill_p1 = XW'(fill_count) + XW'(1);
  assign per_eff = (period == '0) ? PER_W'(1) : period;
  assign pc_p1   = period_count + PER_W'(1);

  always_comb begin
    if ((prod[P_W-1] == prod[VAL_W-1]) && (prod[P_W-2] == prod[VAL_W-1])) begin
      prod_sat = prod[VAL_W-1:0];
    end else begin
      prod_sat = prod[P_W-1] ? VMIN : VMAX;
    end
    acc_sum = {acc[VAL_W-1], acc} + {prod_sat[VAL_W-1], prod_sat};
    if (acc_sum[VAL_W] != acc_sum[VAL_W-1]) begin
      acc_next = acc_sum[VAL_W] ? VMIN : VMAX;
    end else begin
      acc_next = acc_sum[VAL_W-1:0];
    end
  end

  assign dividend = cmd.div_mean ? VAL_W'(sum) : acc;

  swc_div #(
    .DEN_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (fill_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign n_cnt         = fill_count;
  assign sts.recompute = recompute;
  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_q <= in_data;
    end
    if (cmd.wr_sample) begin
      mem[{write_slot, cmd.dim}] <= word;
    end
    rd <= mem[{back_slot, cmd.dim}];
    if (cmd.wr_mean) begin
      mean_mem[cmd.row[DIM_W-1:0]] <= quotient[SAMPLE_W-1:0];
    end
    if (cmd.rd_mean) begin
      mean_rd <= mean_mem[cmd.mean_idx];
    end
    if (cmd.ld_mi) begin
      mi <= mean_rd;
    end
    if (cmd.ld_mj) begin
      mj <= mean_rd;
    end
    if (cmd.ld_di) begin
      di <= D_W'(rd) - D_W'(mi);
    end
    if (cmd.ld_dj) begin
      dj <= D_W'(rd) - D_W'(mj);
    end
    if (cmd.mul) begin
      prod <= di * dj;
    end
    if (cmd.clr) begin
      sum <= '0;
      acc <= '0;
    end else begin
      if (cmd.acc_sum) begin
        sum <= sum + SUM_W'(rd);
      end
      if (cmd.acc_prod) begin
        acc <= acc_next;
      end
    end
    if (cmd.load_out) begin
      out_data.row          <= cmd.row;
      out_data.col          <= cmd.col;
      out_data.cov_value    <= quotient;
      out_data.sample_count <= COUNT_W'(fill_count);
      out_data.last         <= (cmd.row == IDX_W'(DIMENSION - 1)) && (cmd.col == cmd.row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen         <= WLEN_RESET;
      period       <= PER_RESET;
      write_slot   <= '0;
      fill_count   <= '0;
      period_count <= '0;
      recompute    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WINDOW_LEN:       wlen   <= cfg_data[WLEN_W-1:0];
          CFG_RECOMPUTE_PERIOD: period <= cfg_data[PER_W-1:0];
          default:              period <= period;
        endcase
      end
      if (cmd.update) begin
        write_slot <= (write_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : write_slot + SLOT_W'(1);
        fill_count <= (fill_p1 > wl_eff) ? wl_eff[CNT_W-1:0] : fill_p1[CNT_W-1:0];
        if (pc_p1 < per_eff) begin
          period_count <= pc_p1;
          recompute    <= 1'b0;
        end else begin
          period_count <= '0;
          recompute    <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/sliding_window_covariance.sv =====
// Top level of the sliding-window covariance block.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_stall  | one six-element sample
//   out     | output    | out_valid / out_stall| one lower-triangle entry
//   cfg     | input     | cfg_we               | one register write
//
// A sample is written to the store one element at a time, then the count is
// updated and the recompute is checked before the next beat is accepted. On a
// recompute item, the means and then the 21 entries are computed, output stalls
// adding to the time; the bit-serial divider takes most of it.
// in_stall is high after an accepted beat until the sequencer is idle again.
// The output register is free to drain while the next entry is computed.
// Reset (rst, synchronous) clears counters and restores window_len 10, period 5.
module sliding_window_covariance
  import swc_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  swc_cmd_t                          cmd;
  swc_sts_t                          sts;
  logic [$clog2(WINDOW_MAX+1)-1:0]   n_cnt;
  logic [$clog2(WINDOW_MAX)-1:0]     k_idx;

  swc_ctrl #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .n_cnt    (n_cnt),
    .cmd      (cmd),
    .k_idx    (k_idx)
  );

  swc_dp #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .k_idx     (k_idx),
    .sts       (sts),
    .n_cnt     (n_cnt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_take_while_dividing: assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> in_stall)
    else $error("input taken while the divider runs");

  a_lower_triangle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.col <= out_data.row))
    else $error("entry above the diagonal");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (n_cnt != '0))
    else $error("matrix emitted from an empty window");

endmodule
